// ===== hdl/mes_pkg.sv =====
package mes_pkg;

  // Channel count and field widths.
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned CH_W     = $clog2(NUM_CH);
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned AVG_W    = 20;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned OUT_W    = 15;
  localparam int unsigned FRAC_W   = 8;

  // Full scale of the converter. The mapping divider relies on it being 2^12 - 1.
  localparam int unsigned SAMPLE_FULL_SCALE = 4095;
  localparam logic [AVG_W-1:0] FULL_Q = AVG_W'(SAMPLE_FULL_SCALE << FRAC_W);

  // Shared multiplier: 21-bit signed by 17-bit signed.
  localparam int unsigned MUL_A_W = AVG_W + 1;
  localparam int unsigned MUL_B_W = ALPHA_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Stream packing.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CH0_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CH0_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CH1_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CH1_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CH2_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CH2_MAX = 3'd6;

  // Register reset values.
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 16'd6554;
  localparam logic [OUT_W-1:0]   CH0_MIN_RST = 15'd128;
  localparam logic [OUT_W-1:0]   CH0_MAX_RST = 15'd1280;
  localparam logic [OUT_W-1:0]   CH1_MIN_RST = 15'd5120;
  localparam logic [OUT_W-1:0]   CH1_MAX_RST = 15'd20480;
  localparam logic [OUT_W-1:0]   CH2_MIN_RST = 15'd3840;
  localparam logic [OUT_W-1:0]   CH2_MAX_RST = 15'd12800;

  // Operation codes carried in tuser.
  localparam logic OP_SEED   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Datapath step selected by the controller.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_EMA_MUL,
    DP_EMA_UPD,
    DP_MAP_MUL,
    DP_MAP_OUT
  } dp_step_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic            load;
    logic            seed;
    dp_step_e        step;
    logic [CH_W-1:0] ch;
    logic            publish;
  } dp_cmd_t;

endpackage

// ===== hdl/mes_datapath.sv =====
module mes_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mes_pkg::dp_cmd_t             cmd_i,
  input  logic                         cfg_we_i,
  input  logic [mes_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mes_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Fields from bit 0: sample_a, sample_b, sample_c, zero fill.
  input  logic [mes_pkg::IN_DATA_W-1:0]  in_data_i,
  // Fields from bit 0: mapped_a, mapped_b, mapped_c, zero fill.
  output logic [mes_pkg::OUT_DATA_W-1:0] out_data_o
);
  import mes_pkg::*;

  logic [ALPHA_W-1:0]  alpha_q;
  logic [OUT_W-1:0]    lo_q [NUM_CH];
  logic [OUT_W-1:0]    hi_q [NUM_CH];
  logic [SAMPLE_W-1:0] sample_q [NUM_CH];
  logic [AVG_W-1:0]    avg_q [NUM_CH];
  logic [OUT_W-1:0]    res_q [NUM_CH];
  logic [OUT_W-1:0]    out_q [NUM_CH];
  logic signed [MUL_P_W-1:0] prod_q;
  logic                neg_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [AVG_W-1:0]    avg_cur;
  logic [AVG_W-1:0]    raw_cur;
  logic [AVG_W-1:0]    v_clamp;
  logic signed [OUT_W:0] span;
  logic [OUT_W-1:0]    span_mag;
  logic signed [AVG_W+1:0] avg_new;
  logic [26:0]         quo_in;
  logic [15:0]         part_s;
  logic [12:0]         part_t;
  logic [OUT_W:0]      quot;
  logic [OUT_W:0]      mapped;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RST;
      lo_q[0]  <= CH0_MIN_RST;
      hi_q[0]  <= CH0_MAX_RST;
      lo_q[1]  <= CH1_MIN_RST;
      hi_q[1]  <= CH1_MAX_RST;
      lo_q[2]  <= CH2_MIN_RST;
      hi_q[2]  <= CH2_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ALPHA:   alpha_q <= cfg_data_i[ALPHA_W-1:0];
        REG_CH0_MIN: lo_q[0] <= cfg_data_i[OUT_W-1:0];
        REG_CH0_MAX: hi_q[0] <= cfg_data_i[OUT_W-1:0];
        REG_CH1_MIN: lo_q[1] <= cfg_data_i[OUT_W-1:0];
        REG_CH1_MAX: hi_q[1] <= cfg_data_i[OUT_W-1:0];
        REG_CH2_MIN: lo_q[2] <= cfg_data_i[OUT_W-1:0];
        REG_CH2_MAX: hi_q[2] <= cfg_data_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Operands of the channel in work.
  always_comb begin
    avg_cur  = avg_q[cmd_i.ch];
    raw_cur  = {sample_q[cmd_i.ch], {FRAC_W{1'b0}}};
    v_clamp  = (avg_cur > FULL_Q) ? FULL_Q : avg_cur;
    span     = $signed({1'b0, hi_q[cmd_i.ch]}) - $signed({1'b0, lo_q[cmd_i.ch]});
    span_mag = span[OUT_W] ? OUT_W'(-span) : span[OUT_W-1:0];
  end

  // Shared multiplier: alpha times the sample step, or clamped average times span.
  always_comb begin
    if (cmd_i.step == DP_MAP_MUL) begin
      mul_a = $signed({1'b0, v_clamp});
      mul_b = $signed({2'b00, span_mag});
    end else begin
      mul_a = $signed({1'b0, raw_cur}) - $signed({1'b0, avg_cur});
      mul_b = $signed({1'b0, alpha_q});
    end
    mul_p = mul_a * mul_b;
  end

  // The blend is avg + floor(alpha * (raw - avg) / 2^16).
  assign avg_new = $signed({2'b00, avg_cur}) + $signed(prod_q[MUL_P_W-1:16]);

  // Division by the full scale: drop the fraction bits, then divide by 4095
  // through two folds of the 4096 split and one final compare.
  always_comb begin
    quo_in = prod_q[34:8];
    part_s = {1'b0, quo_in[26:12]} + {4'd0, quo_in[11:0]};
    part_t = {9'd0, part_s[15:12]} + {1'b0, part_s[11:0]};
    quot   = {1'b0, quo_in[26:12]} + {12'd0, part_s[15:12]}
           + {15'd0, (part_t >= 13'(SAMPLE_FULL_SCALE))};
    mapped = neg_q ? ({1'b0, lo_q[cmd_i.ch]} - quot) : ({1'b0, lo_q[cmd_i.ch]} + quot);
  end

  // Averages and captured samples.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        avg_q[i] <= '0;
      end
    end else if (cmd_i.seed) begin
      for (int i = 0; i < NUM_CH; i++) begin
        avg_q[i] <= {in_data_i[i*SAMPLE_W +: SAMPLE_W], {FRAC_W{1'b0}}};
      end
    end else if (cmd_i.step == DP_EMA_UPD) begin
      avg_q[cmd_i.ch] <= avg_new[AVG_W-1:0];
    end
  end

  // Payload registers of the step sequence.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sample_q[i] <= in_data_i[i*SAMPLE_W +: SAMPLE_W];
      end
    end
    if (cmd_i.step == DP_EMA_MUL || cmd_i.step == DP_MAP_MUL) begin
      prod_q <= mul_p;
    end
    if (cmd_i.step == DP_MAP_MUL) begin
      neg_q <= span[OUT_W];
    end
    if (cmd_i.step == DP_MAP_OUT) begin
      res_q[cmd_i.ch] <= mapped[OUT_W-1:0];
    end
    if (cmd_i.publish) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    out_data_o = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      out_data_o[i*OUT_W +: OUT_W] = out_q[i];
    end
  end

endmodule

// ===== hdl/mes_controller.sv =====
module mes_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mes_pkg::dp_cmd_t cmd_o
);
  import mes_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMA_MUL,
    ST_EMA_UPD,
    ST_MAP_MUL,
    ST_MAP_OUT,
    ST_PUBLISH
  } state_e;

  state_e          state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic            seeded_q, seeded_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Step sequencing: four steps per channel, then the result is published.
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.load    = accept;
    cmd_o.seed    = accept && (in_op_i == OP_SEED);
    cmd_o.step    = DP_NONE;
    cmd_o.ch      = ch_q;
    cmd_o.publish = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_op_i == OP_SEED) begin
          seeded_d = 1'b1;
        end else if (accept && seeded_q) begin
          ch_d    = '0;
          state_d = ST_EMA_MUL;
        end
      end
      ST_EMA_MUL: begin
        cmd_o.step = DP_EMA_MUL;
        state_d    = ST_EMA_UPD;
      end
      ST_EMA_UPD: begin
        cmd_o.step = DP_EMA_UPD;
        state_d    = ST_MAP_MUL;
      end
      ST_MAP_MUL: begin
        cmd_o.step = DP_MAP_MUL;
        state_d    = ST_MAP_OUT;
      end
      ST_MAP_OUT: begin
        cmd_o.step = DP_MAP_OUT;
        if (ch_q == CH_W'(NUM_CH - 1)) begin
          state_d = ST_PUBLISH;
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = ST_EMA_MUL;
        end
      end
      ST_PUBLISH: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_seed_sets_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op_i == OP_SEED |=> seeded_q)
    else $error("seed transfer did not mark the block seeded");

  a_unseeded_update_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op_i == OP_UPDATE && !seeded_q |=> state_q == ST_IDLE)
    else $error("update before seed started a computation");

  a_channel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> ch_q <= CH_W'(NUM_CH - 1))
    else $error("channel counter beyond the last channel");

  a_publish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUBLISH && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("published result not presented");
`endif

endmodule

// ===== hdl/multichannel_ema_scaler.sv =====
// Channel  | Direction | Transfer moves
// s_axis   | in        | tuser: operation; tdata: sample_a, sample_b, sample_c
// m_axis   | out       | tdata: mapped_a, mapped_b, mapped_c
// cfg      | in        | register index and write data, always ready
//
// A seed item, or an update before any seed, gives no result and leaves the input ready.
// An update item holds the block after its transfer until it is done: four steps per
// channel on the single shared multiplier (blend product, average update, map product,
// divide and offset), then a publish step that loads the output register when free.
// Reset clears the averages, the seeded flag and the output valid, and restores
// the register defaults. While a result waits on m_axis_tready, the next item may
// be computed but is held before loading the output register.
module multichannel_ema_scaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: sample_a, sample_b, sample_c, zero fill.
  input  logic [mes_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: operation.
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: mapped_a, mapped_b, mapped_c, zero fill.
  output logic [mes_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mes_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mes_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mes_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Step sequencer and handshakes.
  mes_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Averages, registers, shared multiplier and output register.
  mes_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata)
  );

endmodule
